// File: hw/rtl/dhtr_pkg.sv
// Shared types, codes and constants for the single-wire sensor receiver.
// No dependencies; imported by every module of the block.
package dhtr_pkg;

	// APB address width: five 32-bit registers at byte offsets 0..16
	localparam int ADDR_W = 5;

	// Register reset values
	localparam logic        RST_ENABLED      = 1'b0;
	localparam logic [15:0] RST_START_LOW    = 16'd25000;
	localparam logic [7:0]  RST_ANSWER_DELAY = 8'd27;
	localparam logic [7:0]  RST_SAMPLE_DELAY = 8'd40;
	localparam logic [15:0] RST_EDGE_TIMEOUT = 16'd1000;

	// Frame layout and range limits
	localparam logic [5:0] DATA_BITS  = 6'd32;
	localparam logic [5:0] TOTAL_BITS = 6'd40;
	localparam logic [7:0] TEMP_LIMIT = 8'd70;
	localparam logic [7:0] HUMI_LIMIT = 8'd100;

	// Register indexes (word address)
	typedef enum logic [2:0] {
		REG_ENABLED      = 3'd0,
		REG_START_LOW    = 3'd1,
		REG_ANSWER_DELAY = 3'd2,
		REG_SAMPLE_DELAY = 3'd3,
		REG_EDGE_TIMEOUT = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_NOT_ENABLED = 2'd1,
		ST_NO_ANSWER   = 2'd2,
		ST_TIMEOUT     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		PH_IDLE      = 3'd0,
		PH_START_LOW = 3'd1,
		PH_ANSWER    = 3'd2,
		PH_ACK_HIGH  = 3'd3,
		PH_WAIT_LOW  = 3'd4,
		PH_WAIT_HIGH = 3'd5,
		PH_SAMPLE    = 3'd6
	} phase_t;

	typedef struct packed {
		logic        enabled;
		logic [15:0] start_low;
		logic [7:0]  answer_delay;
		logic [7:0]  sample_delay;
		logic [15:0] edge_timeout;
	} cfg_t;

	typedef struct packed {
		logic       drive_low;
		logic       busy;
		logic       done;
		status_t    status;
		logic [7:0] temperature;
		logic [7:0] humidity;
		logic [7:0] checksum;
		logic       temperature_valid;
		logic       humidity_valid;
	} result_t;

endpackage

// File: hw/rtl/dhtr_cfg.sv
// APB register file for the receiver timing settings.
// Depends on dhtr_pkg (cfg_t, register indexes, reset values).
module dhtr_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [dhtr_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	output dhtr_pkg::cfg_t             cfg
);
	import dhtr_pkg::*;

	cfg_t cfg_q;
	logic wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[ADDR_W-1:2];
	assign cfg    = cfg_q;

	// register writes; indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enabled      <= RST_ENABLED;
			cfg_q.start_low    <= RST_START_LOW;
			cfg_q.answer_delay <= RST_ANSWER_DELAY;
			cfg_q.sample_delay <= RST_SAMPLE_DELAY;
			cfg_q.edge_timeout <= RST_EDGE_TIMEOUT;
		end else if (wr_en) begin
			case (idx)
				REG_ENABLED:      cfg_q.enabled      <= pwdata[0];
				REG_START_LOW:    cfg_q.start_low    <= pwdata[15:0];
				REG_ANSWER_DELAY: cfg_q.answer_delay <= pwdata[7:0];
				REG_SAMPLE_DELAY: cfg_q.sample_delay <= pwdata[7:0];
				REG_EDGE_TIMEOUT: cfg_q.edge_timeout <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (idx)
			REG_ENABLED:      prdata = {31'd0, cfg_q.enabled};
			REG_START_LOW:    prdata = {16'd0, cfg_q.start_low};
			REG_ANSWER_DELAY: prdata = {24'd0, cfg_q.answer_delay};
			REG_SAMPLE_DELAY: prdata = {24'd0, cfg_q.sample_delay};
			REG_EDGE_TIMEOUT: prdata = {16'd0, cfg_q.edge_timeout};
			default:          prdata = 32'd0;
		endcase
	end

endmodule

// File: hw/rtl/dhtr_core.sv
// Phase machine, tick counter and shift registers of the sensor read.
// Depends on dhtr_pkg; updates once per accepted transaction.
module dhtr_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic              action,
	input  logic              line_level,
	input  dhtr_pkg::cfg_t    cfg,
	output dhtr_pkg::result_t res
);
	import dhtr_pkg::*;

	phase_t      phase_q, phase_d;
	logic [15:0] tick_q, tick_d;
	logic [5:0]  bit_q, bit_d;
	logic [31:0] data_q, data_d;
	logic [7:0]  chk_q, chk_d;
	status_t     status_q, status_d;
	logic [7:0]  temp_q, temp_d;
	logic [7:0]  hum_q, hum_d;
	logic [7:0]  lchk_q, lchk_d;
	logic        done;

	logic [15:0] cnt_inc;
	logic [15:0] limit;
	logic        reached;
	logic [5:0]  bit_inc;

	assign cnt_inc = tick_q + 16'd1;
	assign bit_inc = bit_q + 6'd1;
	assign reached = (cnt_inc >= limit);

	// count limit of the current phase
	always_comb begin
		case (phase_q)
			PH_START_LOW: limit = cfg.start_low;
			PH_ANSWER:    limit = {8'd0, cfg.answer_delay};
			PH_SAMPLE:    limit = {8'd0, cfg.sample_delay};
			default:      limit = cfg.edge_timeout;
		endcase
	end

	// next state
	always_comb begin
		phase_d  = phase_q;
		tick_d   = tick_q;
		bit_d    = bit_q;
		data_d   = data_q;
		chk_d    = chk_q;
		status_d = status_q;
		temp_d   = temp_q;
		hum_d    = hum_q;
		lchk_d   = lchk_q;
		done     = 1'b0;
		if (action && phase_q == PH_IDLE) begin
			if (!cfg.enabled) begin
				status_d = ST_NOT_ENABLED;
				tick_d   = 16'd0;
				done     = 1'b1;
			end else begin
				phase_d = PH_START_LOW;
				tick_d  = 16'd0;
				bit_d   = 6'd0;
				data_d  = 32'd0;
				chk_d   = 8'd0;
			end
		end else if (phase_q != PH_IDLE) begin
			case (phase_q)
				PH_START_LOW: begin
					tick_d = cnt_inc;
					if (reached) begin
						phase_d = PH_ANSWER;
						tick_d  = 16'd0;
					end
				end
				PH_ANSWER: begin
					tick_d = cnt_inc;
					if (reached) begin
						tick_d = 16'd0;
						if (!line_level) begin
							phase_d = PH_ACK_HIGH;
						end else begin
							phase_d  = PH_IDLE;
							status_d = ST_NO_ANSWER;
						end
					end
				end
				PH_ACK_HIGH, PH_WAIT_LOW, PH_WAIT_HIGH: begin
					// edge waits: the awaited level ends the wait at once
					if (line_level == (phase_q != PH_WAIT_LOW)) begin
						tick_d = 16'd0;
						case (phase_q)
							PH_ACK_HIGH: begin
								phase_d = PH_WAIT_LOW;
								bit_d   = 6'd0;
							end
							PH_WAIT_LOW: phase_d = PH_WAIT_HIGH;
							default:     phase_d = PH_SAMPLE;
						endcase
					end else begin
						tick_d = cnt_inc;
						if (reached) begin
							phase_d  = PH_IDLE;
							tick_d   = 16'd0;
							status_d = ST_TIMEOUT;
						end
					end
				end
				PH_SAMPLE: begin
					tick_d = cnt_inc;
					if (reached) begin
						if (bit_q < DATA_BITS) begin
							data_d = {data_q[30:0], line_level};
						end else begin
							chk_d = {chk_q[6:0], line_level};
						end
						bit_d  = bit_inc;
						tick_d = 16'd0;
						if (bit_inc >= TOTAL_BITS) begin
							phase_d  = PH_IDLE;
							status_d = ST_OK;
							temp_d   = data_d[15:8];
							hum_d    = data_d[31:24];
							lchk_d   = chk_d;
						end else begin
							phase_d = PH_WAIT_LOW;
						end
					end
				end
				default: begin
					phase_d = PH_IDLE;
					tick_d  = 16'd0;
				end
			endcase
			done = (phase_d == PH_IDLE);
		end
	end

	// result fields from the updated state
	always_comb begin
		res.drive_low         = (phase_d == PH_START_LOW);
		res.busy              = (phase_d != PH_IDLE);
		res.done              = done;
		res.status            = status_d;
		res.temperature       = temp_d;
		res.humidity          = hum_d;
		res.checksum          = lchk_d;
		res.temperature_valid = (status_d == ST_OK) && (temp_d < TEMP_LIMIT);
		res.humidity_valid    = (status_d == ST_OK) && (hum_d <= HUMI_LIMIT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			tick_q   <= 16'd0;
			bit_q    <= 6'd0;
			data_q   <= 32'd0;
			chk_q    <= 8'd0;
			status_q <= ST_OK;
			temp_q   <= 8'd0;
			hum_q    <= 8'd0;
			lchk_q   <= 8'd0;
		end else if (accept) begin
			phase_q  <= phase_d;
			tick_q   <= tick_d;
			bit_q    <= bit_d;
			data_q   <= data_d;
			chk_q    <= chk_d;
			status_q <= status_d;
			temp_q   <= temp_d;
			hum_q    <= hum_d;
			lchk_q   <= lchk_d;
		end
	end

endmodule

// File: hw/rtl/dhtr_out_buf.sv
// Output register with one skid entry for the result channel.
// Depends on dhtr_pkg (result_t).
module dhtr_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  dhtr_pkg::result_t in_res,
	output logic              out_valid,
	input  logic              out_stall,
	output dhtr_pkg::result_t out_res
);
	import dhtr_pkg::*;

	logic    out_valid_q, skid_valid_q;
	result_t out_res_q, skid_res_q;
	logic    in_acc, out_acc;

	assign in_stall  = skid_valid_q;
	assign in_acc    = in_valid && !skid_valid_q;
	assign out_acc   = out_valid_q && !out_stall;
	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (out_acc) skid_valid_q <= 1'b0;
			end else if (in_acc) begin
				if (out_valid_q && !out_acc) skid_valid_q <= 1'b1;
				else out_valid_q <= 1'b1;
			end else if (out_acc) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_acc) out_res_q <= skid_res_q;
		end else if (in_acc) begin
			if (out_valid_q && !out_acc) skid_res_q <= in_res;
			else out_res_q <= in_res;
		end
	end

endmodule

// File: hw/rtl/dht11_single_wire_receiver.sv
// Top level of the single-wire humidity/temperature sensor receiver.
// Depends on dhtr_pkg, dhtr_cfg, dhtr_core and dhtr_out_buf.
//
// Usage: each input transaction is one sample tick of the sensor line
// (action = 0) or a start command (action = 1, ignored as a start while
// busy). Every input transaction yields exactly one result transaction
// carrying drive_low, busy/done flags and the last finished reading.
// Drive the sensor pin low whenever the latest drive_low is 1.
// Throughput: one transaction per cycle while in_stall is low, set by the
// single registered pass through the phase machine and tick counter. The
// result is registered in the output register or, on a stall, the skid entry.
// Stall: the result register plus one skid entry absorb a stalled receiver;
// in_stall rises once the skid entry holds a result and falls the cycle
// after the receiver takes one.
// Reset: phase idle, stored reading zero, no result pending, registers at defaults
// (sensor disabled, 25000/27/40/1000 ticks). The APB port may be written
// only while no reading is in progress.
module dht11_single_wire_receiver (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [dhtr_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       action,
	input  logic                       line_level,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       drive_low,
	output logic                       busy_res,
	output logic                       done_res,
	output logic [1:0]                 status,
	output logic [7:0]                 temperature,
	output logic [7:0]                 humidity,
	output logic [7:0]                 checksum,
	output logic                       temperature_valid,
	output logic                       humidity_valid
);
	import dhtr_pkg::*;

	cfg_t    cfg;
	result_t core_res, out_res;
	logic    accept;

	assign accept = in_valid && !in_stall;

	dhtr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	dhtr_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.action     (action),
		.line_level (line_level),
		.cfg        (cfg),
		.res        (core_res)
	);

	dhtr_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_res    (core_res),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res)
	);

	assign drive_low         = out_res.drive_low;
	assign busy_res          = out_res.busy;
	assign done_res          = out_res.done;
	assign status            = out_res.status;
	assign temperature       = out_res.temperature;
	assign humidity          = out_res.humidity;
	assign checksum          = out_res.checksum;
	assign temperature_valid = out_res.temperature_valid;
	assign humidity_valid    = out_res.humidity_valid;

	// input is held off only while a result waits in the skid entry
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no pending result");

	// an accepted transaction always leaves a result behind
	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> out_valid)
		else $error("accepted transaction produced no result");

	// the line is only pulled low during a reading
	a_drive_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && drive_low) |-> busy_res)
		else $error("drive_low outside a reading");

	// a finished reading leaves the block idle
	a_done_is_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && done_res) |-> (!busy_res && !drive_low))
		else $error("done reported while still busy");

endmodule

// File: tb/dhtr_reading_checker.sv
// Scoreboard for the single-wire sensor receiver: mirrors the APB registers, predicts the
// result of every accepted input transaction and checks the result channel against it.
// Depends on dhtr_pkg; instantiated beside the block by the tb top.
module dhtr_reading_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [dhtr_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	input  logic [31:0]                 prdata,
	input  logic                        pready,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  logic                        action,
	input  logic                        line_level,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic                        drive_low,
	input  logic                        busy_res,
	input  logic                        done_res,
	input  logic [1:0]                  status,
	input  logic [7:0]                  temperature,
	input  logic [7:0]                  humidity,
	input  logic [7:0]                  checksum,
	input  logic                        temperature_valid,
	input  logic                        humidity_valid,
	output int                          mismatch_count,
	output int                          results_owed,
	output bit                          reading_active
);
	import dhtr_pkg::*;

	// Register mirror and reading state
	cfg_t        regs;
	phase_t      rd_phase;
	logic [15:0] tick_cnt;
	logic [5:0]  bit_cnt;
	logic [31:0] word_sr;
	logic [7:0]  csum_sr;
	status_t     last_status;
	logic [7:0]  last_temp;
	logic [7:0]  last_humi;
	logic [7:0]  last_csum;
	result_t     readings_due[$];

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch in %s at %0t: got %0h, want %0h", what, $time, got, want);
		mismatch_count++;
	endtask

	// One tick of a wait; true once the wait has lasted lim ticks (zero behaves as one)
	function automatic logic count_hits(input logic [15:0] lim);
		tick_cnt = tick_cnt + 16'd1;
		return tick_cnt >= lim;
	endfunction

	function automatic void close_reading(input status_t st);
		last_status = st;
		rd_phase = PH_IDLE;
		tick_cnt = '0;
	endfunction

	// Sensor-line tick while a reading is in progress
	function automatic void advance_reading(input logic lv);
		case (rd_phase)
			PH_START_LOW: begin
				if (count_hits(regs.start_low)) begin
					rd_phase = PH_ANSWER;
					tick_cnt = '0;
				end
			end
			PH_ANSWER: begin
				if (count_hits({8'd0, regs.answer_delay})) begin
					if (!lv) begin
						rd_phase = PH_ACK_HIGH;
						tick_cnt = '0;
					end else begin
						close_reading(ST_NO_ANSWER);
					end
				end
			end
			PH_ACK_HIGH: begin
				if (lv) begin
					rd_phase = PH_WAIT_LOW;
					tick_cnt = '0;
					bit_cnt = '0;
				end else if (count_hits(regs.edge_timeout)) begin
					close_reading(ST_TIMEOUT);
				end
			end
			PH_WAIT_LOW: begin
				if (!lv) begin
					rd_phase = PH_WAIT_HIGH;
					tick_cnt = '0;
				end else if (count_hits(regs.edge_timeout)) begin
					close_reading(ST_TIMEOUT);
				end
			end
			PH_WAIT_HIGH: begin
				if (lv) begin
					rd_phase = PH_SAMPLE;
					tick_cnt = '0;
				end else if (count_hits(regs.edge_timeout)) begin
					close_reading(ST_TIMEOUT);
				end
			end
			PH_SAMPLE: begin
				if (count_hits({8'd0, regs.sample_delay})) begin
					if (bit_cnt < DATA_BITS)
						word_sr = {word_sr[30:0], lv};
					else
						csum_sr = {csum_sr[6:0], lv};
					bit_cnt = bit_cnt + 6'd1;
					if (bit_cnt >= TOTAL_BITS) begin
						// frame complete: latch the bytes, checksum is not verified
						last_temp = word_sr[15:8];
						last_humi = word_sr[31:24];
						last_csum = csum_sr;
						close_reading(ST_OK);
					end else begin
						rd_phase = PH_WAIT_LOW;
						tick_cnt = '0;
					end
				end
			end
			default: begin
				rd_phase = PH_IDLE;
				tick_cnt = '0;
			end
		endcase
	endfunction

	// Expected result of one input transaction
	function automatic result_t predict_reading(input logic act, input logic lv);
		result_t r;
		logic    was_busy;
		logic    done;
		was_busy = (rd_phase != PH_IDLE);
		done = 1'b0;
		if (act && !was_busy) begin
			if (!regs.enabled) begin
				close_reading(ST_NOT_ENABLED);
				done = 1'b1;
			end else begin
				rd_phase = PH_START_LOW;
				tick_cnt = '0;
				bit_cnt = '0;
				word_sr = '0;
				csum_sr = '0;
			end
		end else if (was_busy) begin
			// a start while busy is just another tick
			advance_reading(lv);
			done = (rd_phase == PH_IDLE);
		end
		r.drive_low = (rd_phase == PH_START_LOW);
		r.busy = (rd_phase != PH_IDLE);
		r.done = done;
		r.status = last_status;
		r.temperature = last_temp;
		r.humidity = last_humi;
		r.checksum = last_csum;
		r.temperature_valid = (last_status == ST_OK) && (last_temp < TEMP_LIMIT);
		r.humidity_valid = (last_status == ST_OK) && (last_humi <= HUMI_LIMIT);
		return r;
	endfunction

	// Register mirror, prediction on input transactions, comparison on result transactions
	always @(posedge clk or negedge arst_n) begin : watch
		result_t     want;
		logic [31:0] rd_want;
		if (!arst_n) begin
			regs.enabled = RST_ENABLED;
			regs.start_low = RST_START_LOW;
			regs.answer_delay = RST_ANSWER_DELAY;
			regs.sample_delay = RST_SAMPLE_DELAY;
			regs.edge_timeout = RST_EDGE_TIMEOUT;
			rd_phase = PH_IDLE;
			tick_cnt = '0;
			bit_cnt = '0;
			word_sr = '0;
			csum_sr = '0;
			last_status = ST_OK;
			last_temp = '0;
			last_humi = '0;
			last_csum = '0;
			readings_due.delete();
			mismatch_count = 0;
			results_owed = 0;
			reading_active = 1'b0;
		end else begin
			// APB access phase
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (reg_idx_t'(paddr[ADDR_W-1:2]))
						REG_ENABLED:      regs.enabled = pwdata[0];
						REG_START_LOW:    regs.start_low = pwdata[15:0];
						REG_ANSWER_DELAY: regs.answer_delay = pwdata[7:0];
						REG_SAMPLE_DELAY: regs.sample_delay = pwdata[7:0];
						REG_EDGE_TIMEOUT: regs.edge_timeout = pwdata[15:0];
						default: ;
					endcase
				end else begin
					case (reg_idx_t'(paddr[ADDR_W-1:2]))
						REG_ENABLED:      rd_want = {31'd0, regs.enabled};
						REG_START_LOW:    rd_want = {16'd0, regs.start_low};
						REG_ANSWER_DELAY: rd_want = {24'd0, regs.answer_delay};
						REG_SAMPLE_DELAY: rd_want = {24'd0, regs.sample_delay};
						REG_EDGE_TIMEOUT: rd_want = {16'd0, regs.edge_timeout};
						default:          rd_want = prdata;
					endcase
					if (prdata !== rd_want)
						report("register read", prdata, rd_want);
				end
			end

			// result side first: a result never belongs to an input of the same edge
			if (out_valid && !out_stall) begin
				if (readings_due.size() == 0) begin
					report("result with nothing owed", '0, '0);
				end else begin
					want = readings_due.pop_front();
					if (drive_low !== want.drive_low)
						report("drive_low", 32'(drive_low), 32'(want.drive_low));
					if (busy_res !== want.busy)
						report("busy_res", 32'(busy_res), 32'(want.busy));
					if (done_res !== want.done)
						report("done_res", 32'(done_res), 32'(want.done));
					if (status !== want.status)
						report("status", 32'(status), 32'(want.status));
					if (temperature !== want.temperature)
						report("temperature", 32'(temperature), 32'(want.temperature));
					if (humidity !== want.humidity)
						report("humidity", 32'(humidity), 32'(want.humidity));
					if (checksum !== want.checksum)
						report("checksum", 32'(checksum), 32'(want.checksum));
					if (temperature_valid !== want.temperature_valid)
						report("temperature_valid", 32'(temperature_valid),
							32'(want.temperature_valid));
					if (humidity_valid !== want.humidity_valid)
						report("humidity_valid", 32'(humidity_valid),
							32'(want.humidity_valid));
				end
			end

			if (in_valid && !in_stall)
				readings_due.push_back(predict_reading(action, line_level));

			results_owed = readings_due.size();
			reading_active = (rd_phase != PH_IDLE);
		end
	end

endmodule

// File: tb/tb.sv
// Testbench top for the single-wire sensor receiver: clock, reset, APB setup and
// sensor-line stimulus with random idling on both channels, plus the verdict.
// Depends on dhtr_pkg, dht11_single_wire_receiver and dhtr_reading_checker.
module tb;
	import dhtr_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 4_000_000;
	localparam int          ITEM_BUDGET = 1150;
	localparam int          CALM_AFTER  = 950;
	localparam int          SLOW_AFTER  = 500;

	typedef enum int {
		FRAME_CLEAN,
		FRAME_NO_ANSWER,
		FRAME_TIMEOUT,
		FRAME_CUT
	} frame_kind_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic              action = 1'b0;
	logic              line_level = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              drive_low;
	logic              busy_res;
	logic              done_res;
	logic [1:0]        status;
	logic [7:0]        temperature;
	logic [7:0]        humidity;
	logic [7:0]        checksum;
	logic              temperature_valid;
	logic              humidity_valid;

	int                mismatch_count;
	int                results_owed;
	bit                reading_active;

	bit                calm = 1'b0;
	int                items_counted = 0;
	int unsigned       cycle_count = 0;

	// Effective timing of the current setup (a zero register behaves as one)
	bit                sensor_on;
	int                hold_ticks;
	int                answer_ticks;
	int                sample_ticks;
	int                edge_limit;

	dht11_single_wire_receiver DUT (.*);
	dhtr_reading_checker reading_check (.*);

	always #10 clk = ~clk;

	// Run guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Receiver stalls in random bursts
	initial begin
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 15) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 18)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// One input transaction; starts and ends at a falling edge, valid stays high after it
	task automatic send_item(input logic act, input logic lv);
		if (!calm && $urandom_range(0, 15) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		items_counted++;
		in_valid <= 1'b1;
		action <= act;
		line_level <= lv;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic hold_for_results();
		in_valid <= 1'b0;
		@(negedge clk);
		while (results_owed != 0) @(negedge clk);
	endtask

	// Bring the block to idle: a steady high line ends any reading
	task automatic settle();
		hold_for_results();
		while (reading_active) send_item(1'b0, 1'b1);
		hold_for_results();
	endtask

	task automatic reg_access(input reg_idx_t idx, input logic wr, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_config(input logic en, input logic [15:0] sl, input logic [7:0] ad,
			input logic [7:0] sd, input logic [15:0] tmo);
		settle();
		reg_access(REG_ENABLED, 1'b1, {31'd0, en});
		reg_access(REG_START_LOW, 1'b1, {16'd0, sl});
		reg_access(REG_ANSWER_DELAY, 1'b1, {24'd0, ad});
		reg_access(REG_SAMPLE_DELAY, 1'b1, {24'd0, sd});
		reg_access(REG_EDGE_TIMEOUT, 1'b1, {16'd0, tmo});
		for (int i = 0; i <= int'(REG_EDGE_TIMEOUT); i++)
			reg_access(reg_idx_t'(i), 1'b0, '0);
		sensor_on = en;
		hold_ticks = (sl == 0) ? 1 : int'(sl);
		answer_ticks = (ad == 0) ? 1 : int'(ad);
		sample_ticks = (sd == 0) ? 1 : int'(sd);
		edge_limit = (tmo == 0) ? 1 : int'(tmo);
	endtask

	// A start during a reading only counts as a tick
	function automatic logic stray_start();
		return $urandom_range(0, 7) == 0;
	endfunction

	function automatic logic rand_level();
		return 1'($urandom_range(0, 1));
	endfunction

	function automatic int small_or_zero(input int hi);
		if ($urandom_range(0, 19) == 0)
			return 0;
		return $urandom_range(1, hi);
	endfunction

	// Ticks spent before an edge shows up; the longest stays under the timeout, at most cap
	function automatic int edge_lag();
		int cap;
		cap = (edge_limit > 8) ? 8 : edge_limit - 1;
		case ($urandom_range(0, 7))
			0:       return cap;
			1, 2:    return $urandom_range(0, cap);
			default: return 0;
		endcase
	endfunction

	// Bytes around the range limits of temperature and humidity
	function automatic logic [7:0] pick_reading_byte();
		case ($urandom_range(0, 11))
			0:       return 8'd0;
			1:       return 8'd69;
			2:       return 8'd70;
			3:       return 8'd71;
			4:       return 8'd99;
			5:       return 8'd100;
			6:       return 8'd101;
			7:       return 8'd255;
			default: return 8'($urandom);
		endcase
	endfunction

	// One sensor reading as the line would show it, clean or broken
	task automatic run_reading(input frame_kind_t kind);
		logic [39:0] frame;
		logic        level;
		int          fail_at;
		frame = {pick_reading_byte(), 8'($urandom), pick_reading_byte(), 8'($urandom),
			8'($urandom)};
		fail_at = $urandom_range(0, 80);
		while (reading_active) send_item(1'b0, 1'b1);
		send_item(1'b1, rand_level());
		if (!sensor_on)
			return;
		repeat (hold_ticks) send_item(stray_start(), rand_level());
		repeat (answer_ticks - 1) send_item(stray_start(), rand_level());
		if (kind == FRAME_NO_ANSWER) begin
			send_item(stray_start(), 1'b1);
			return;
		end
		send_item(stray_start(), 1'b0);
		// wait 0 is the ack rising edge; then per bit a falling and a rising edge
		for (int w = 0; w <= 80; w++) begin
			level = (w % 2 == 0);
			if (w == fail_at && kind == FRAME_CUT)
				return;
			if (w == fail_at && kind == FRAME_TIMEOUT) begin
				repeat (edge_limit) send_item(stray_start(), !level);
				return;
			end
			repeat (edge_lag()) send_item(stray_start(), !level);
			send_item(stray_start(), level);
			if (w > 0 && level) begin
				repeat (sample_ticks - 1) send_item(stray_start(), rand_level());
				send_item(stray_start(), frame[39 - (w / 2 - 1)]);
			end
		end
	endtask

	// Main stimulus
	initial begin
		bit slow_done;
		int pick;
		slow_done = 1'b0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// idle ticks and starts with the sensor disabled
		send_item(1'b0, 1'b0);
		send_item(1'b0, 1'b1);
		send_item(1'b1, 1'b0);
		send_item(1'b1, 1'b1);

		// shortest timing: no answer, ack timeout, falling-edge timeout
		set_config(1'b1, 16'd1, 8'd1, 8'd1, 16'd1);
		send_item(1'b1, 1'b1);
		send_item(1'b0, 1'b0);
		send_item(1'b0, 1'b1);
		send_item(1'b1, 1'b0);
		send_item(1'b1, 1'b1);
		send_item(1'b0, 1'b0);
		send_item(1'b0, 1'b0);
		send_item(1'b1, 1'b0);
		send_item(1'b0, 1'b1);
		send_item(1'b0, 1'b0);
		send_item(1'b0, 1'b1);
		send_item(1'b0, 1'b1);
		run_reading(FRAME_CLEAN);

		// random setups, mostly well-formed readings
		while (items_counted < ITEM_BUDGET) begin
			if (!slow_done && items_counted >= SLOW_AFTER) begin
				// every register at its top value, read back before the next setup
				set_config(1'b1, 16'hffff, 8'hff, 8'hff, 16'hffff);
				slow_done = 1'b1;
			end
			if (items_counted >= CALM_AFTER)
				calm = 1'b1;
			set_config($urandom_range(0, 7) != 0, 16'(small_or_zero(4)),
				8'(small_or_zero(3)), 8'(small_or_zero(3)), 16'(small_or_zero(6)));
			repeat ($urandom_range(2, 4)) begin
				repeat ($urandom_range(0, 2)) send_item(1'b0, rand_level());
				pick = $urandom_range(0, 9);
				case (pick)
					6:       run_reading(FRAME_NO_ANSWER);
					7:       run_reading(FRAME_TIMEOUT);
					8:       run_reading(FRAME_CUT);
					9: begin
						repeat ($urandom_range(5, 30))
							send_item($urandom_range(0, 3) == 0, rand_level());
					end
					default: run_reading(FRAME_CLEAN);
				endcase
				if ($urandom_range(0, 5) == 0)
					hold_for_results();
			end
		end

		hold_for_results();
		repeat (4) @(negedge clk);
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
